// ===== rtl/erld_pkg.sv =====
// ----------------------------------------------------------------------------
// erld_pkg
// Shared types and constants of the extent run list decoder.
// ----------------------------------------------------------------------------
package erld_pkg;

	localparam int MAX_FIELD_BYTES = 4;
	localparam int CNT_W           = $clog2(MAX_FIELD_BYTES + 1);
	localparam int POS_W           = 3;
	localparam int LANES           = 4;
	localparam int QUEUE_DEPTH     = 4;
	localparam int QA_W            = $clog2(QUEUE_DEPTH);
	localparam int QC_W            = $clog2(QUEUE_DEPTH + 1);

	localparam logic [1:0] ST_RUN       = 2'd0;
	localparam logic [1:0] ST_END       = 2'd1;
	localparam logic [1:0] ST_MALFORMED = 2'd2;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_HEADER,
		PH_LENGTH,
		PH_OFFSET
	} phase_t;

	typedef enum logic [1:0] {
		TERM_NONE,
		TERM_END,
		TERM_MALFORMED
	} term_t;

	typedef struct packed {
		logic        run;
		term_t       term;
		logic [31:0] vcn;
		logic [31:0] lcn;
		logic [31:0] len;
		logic [31:0] rel;
	} erld_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} erld_qstat_t;

endpackage

// ===== rtl/erld_front.sv =====
// ----------------------------------------------------------------------------
// erld_front
// Accepts run list bytes, tracks header/length/offset parsing and the running
// clusters, and posts one queue entry for every byte that yields results.
// ----------------------------------------------------------------------------
module erld_front import erld_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  list_byte,
	input  logic        list_start,
	input  logic        list_last,
	input  logic        cfg_valid,
	input  logic [31:0] target_vcn,
	input  erld_qstat_t qstat,
	output logic        push,
	output erld_entry_t push_entry
);

	phase_t             phase_q, phase_d, ph;
	logic [CNT_W-1:0]   len_left_q, len_left_d;
	logic [CNT_W-1:0]   off_left_q, off_left_d;
	logic [POS_W-1:0]   bpos_q, bpos_d, bpos;
	logic [31:0]        len_acc_q, len_acc_d;
	logic [31:0]        off_acc_q, off_acc_d;
	logic [31:0]        lcn_q, lcn_d, rlcn, lcn_new;
	logic [31:0]        vcn_q, vcn_d, rvcn, vcn_new;
	logic [31:0]        target_q;
	logic               fin, early, accept;
	term_t              term;

	assign in_stall = qstat.full;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			bpos_q   <= '0;
			target_q <= '0;
		end else begin
			if (accept) begin
				phase_q <= phase_d;
				bpos_q  <= bpos_d;
			end
			if (cfg_valid) begin
				target_q <= target_vcn;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			len_left_q <= len_left_d;
			off_left_q <= off_left_d;
			len_acc_q  <= len_acc_d;
			off_acc_q  <= off_acc_d;
			lcn_q      <= lcn_d;
			vcn_q      <= vcn_d;
		end
	end

	always_comb begin
		ph         = list_start ? PH_HEADER : phase_q;
		rlcn       = list_start ? '0 : lcn_q;
		rvcn       = list_start ? '0 : vcn_q;
		bpos       = list_start ? '0 : bpos_q;
		phase_d    = ph;
		bpos_d     = bpos;
		len_left_d = len_left_q;
		off_left_d = off_left_q;
		len_acc_d  = len_acc_q;
		off_acc_d  = off_acc_q;
		fin        = 1'b0;
		early      = 1'b0;
		term       = TERM_NONE;

		unique case (ph)
			PH_IDLE: begin
				early = 1'b1;
			end
			PH_HEADER: begin
				if (list_byte == 8'd0) begin
					early   = 1'b1;
					term    = TERM_END;
					phase_d = PH_IDLE;
				end else if (list_byte[3:0] > 4'(MAX_FIELD_BYTES)
						|| list_byte[7:4] > 4'(MAX_FIELD_BYTES)) begin
					early   = 1'b1;
					term    = TERM_MALFORMED;
					phase_d = PH_IDLE;
				end else begin
					len_left_d = list_byte[CNT_W-1:0];
					off_left_d = list_byte[4 +: CNT_W];
					len_acc_d  = '0;
					off_acc_d  = '0;
					bpos_d     = '0;
					phase_d    = (list_byte[3:0] != 4'd0) ? PH_LENGTH : PH_OFFSET;
				end
			end
			PH_LENGTH: begin
				for (int i = 0; i < LANES; i++) begin
					if (bpos == POS_W'(i)) begin
						len_acc_d[8*i +: 8] = len_acc_q[8*i +: 8] | list_byte;
					end
				end
				bpos_d     = bpos + POS_W'(1);
				len_left_d = len_left_q - CNT_W'(1);
				if (len_left_d == '0) begin
					bpos_d = '0;
					if (off_left_q == '0) begin
						fin = 1'b1;
					end else begin
						phase_d = PH_OFFSET;
					end
				end
			end
			PH_OFFSET: begin
				if (bpos < POS_W'(LANES)) begin
					for (int i = 0; i < LANES; i++) begin
						if (POS_W'(i) < bpos) begin
							off_acc_d[8*i +: 8] = off_acc_q[8*i +: 8];
						end else if (POS_W'(i) == bpos) begin
							off_acc_d[8*i +: 8] = list_byte;
						end else begin
							off_acc_d[8*i +: 8] = {8{list_byte[7]}};
						end
					end
				end
				bpos_d     = bpos + POS_W'(1);
				off_left_d = off_left_q - CNT_W'(1);
				if (off_left_d == '0) begin
					fin = 1'b1;
				end
			end
			default: begin
				early = 1'b1;
			end
		endcase

		lcn_new = rlcn + off_acc_d;
		vcn_new = rvcn + len_acc_d;
		lcn_d   = rlcn;
		vcn_d   = rvcn;
		if (fin) begin
			lcn_d   = lcn_new;
			vcn_d   = vcn_new;
			phase_d = PH_HEADER;
			bpos_d  = '0;
		end
		if (list_last && !early) begin
			term    = TERM_END;
			phase_d = PH_IDLE;
		end
	end

	assign push            = accept && (fin || term != TERM_NONE);
	assign push_entry.run  = fin;
	assign push_entry.term = term;
	assign push_entry.vcn  = rvcn;
	assign push_entry.lcn  = lcn_new;
	assign push_entry.len  = len_acc_d;
	assign push_entry.rel  = target_q - rvcn;

endmodule

// ===== rtl/erld_queue.sv =====
// ----------------------------------------------------------------------------
// erld_queue
// Short queue of decoded entries between the parsing front and the result
// back end.
// ----------------------------------------------------------------------------
module erld_queue import erld_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  erld_entry_t push_entry,
	input  logic        pop,
	output erld_entry_t head,
	output erld_qstat_t qstat
);

	erld_entry_t       slots_q [QUEUE_DEPTH];
	logic [QA_W-1:0]   wr_q, rd_q;
	logic [QC_W-1:0]   count_q;

	function automatic logic [QA_W-1:0] bump(input logic [QA_W-1:0] p);
		bump = (p == QA_W'(QUEUE_DEPTH - 1)) ? '0 : p + QA_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= bump(wr_q);
			end
			if (pop) begin
				rd_q <= bump(rd_q);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + QC_W'(1);
				2'b01:   count_q <= count_q - QC_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_q] <= push_entry;
		end
	end

	assign head        = slots_q[rd_q];
	assign qstat.full  = (count_q == QC_W'(QUEUE_DEPTH));
	assign qstat.empty = (count_q == '0);

endmodule

// ===== rtl/erld_back.sv =====
// ----------------------------------------------------------------------------
// erld_back
// Expands queue entries into result items: the run with its target test,
// then the end or malformed marker, through one output register.
// ----------------------------------------------------------------------------
module erld_back import erld_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  erld_entry_t head,
	input  erld_qstat_t qstat,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [31:0] run_vcn_start,
	output logic [31:0] run_lcn_start,
	output logic [31:0] run_length,
	output logic        target_hit,
	output logic [31:0] target_lcn,
	output logic        last_result
);

	logic        out_valid_q, run_done_q, run_done_d;
	logic        load, emit_run, hit;
	logic [1:0]  status_q, status_d;
	logic [31:0] vcn_q, lcn_q, len_q, tlcn_q;
	logic [31:0] vcn_d, lcn_d, len_d, tlcn_d;
	logic        hit_q, last_q, last_d;

	assign load     = !out_valid_q || !out_stall;
	assign emit_run = head.run && !run_done_q;
	assign hit      = head.rel < head.len;

	always_comb begin
		pop        = 1'b0;
		run_done_d = run_done_q;
		status_d   = ST_RUN;
		vcn_d      = '0;
		lcn_d      = '0;
		len_d      = '0;
		tlcn_d     = '0;
		last_d     = 1'b1;
		if (emit_run) begin
			vcn_d  = head.vcn;
			lcn_d  = head.lcn;
			len_d  = head.len;
			tlcn_d = hit ? head.lcn + head.rel : '0;
			last_d = (head.term == TERM_NONE);
			if (load && !qstat.empty) begin
				pop        = (head.term == TERM_NONE);
				run_done_d = (head.term != TERM_NONE);
			end
		end else begin
			unique case (head.term)
				TERM_MALFORMED: status_d = ST_MALFORMED;
				default:        status_d = ST_END;
			endcase
			if (load && !qstat.empty) begin
				pop        = 1'b1;
				run_done_d = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			run_done_q  <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= !qstat.empty;
			end
			run_done_q <= run_done_d;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			status_q <= status_d;
			vcn_q    <= vcn_d;
			lcn_q    <= lcn_d;
			len_q    <= len_d;
			hit_q    <= emit_run && hit;
			tlcn_q   <= tlcn_d;
			last_q   <= last_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign run_vcn_start = vcn_q;
	assign run_lcn_start = lcn_q;
	assign run_length    = len_q;
	assign target_hit    = hit_q;
	assign target_lcn    = tlcn_q;
	assign last_result   = last_q;

endmodule

// ===== rtl/extent_run_list_decoder_top.sv =====
// ----------------------------------------------------------------------------
// extent_run_list_decoder_top
// Run list decoder: parses header, length and offset bytes and reports each
// run with its virtual start, physical start, length and target lookup.
//
//   channel  direction  handshake             payload
//   in       sink       in_valid / in_stall   list_byte, list_start, list_last
//   cfg      sink       cfg_valid / cfg_ready target_vcn
//   out      source     out_valid / out_stall status, run_*, target_*, last_result
//
// One byte is taken every cycle while the four-entry queue has room.
// Results leave one per cycle from the output register while out_stall is low;
// a byte that closes a run and ends the list gives two results.
// in_stall rises when the queue is full; out_stall only holds the back end.
// Reset leaves the decoder idle, awaiting a list start, with target_vcn at 0.
// ----------------------------------------------------------------------------
module extent_run_list_decoder_top import erld_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  list_byte,
	input  logic        list_start,
	input  logic        list_last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] target_vcn,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [31:0] run_vcn_start,
	output logic [31:0] run_lcn_start,
	output logic [31:0] run_length,
	output logic        target_hit,
	output logic [31:0] target_lcn,
	output logic        last_result
);

	erld_entry_t push_entry, head;
	erld_qstat_t qstat;
	logic        push, pop;

	assign cfg_ready = 1'b1;

	erld_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.list_byte  (list_byte),
		.list_start (list_start),
		.list_last  (list_last),
		.cfg_valid  (cfg_valid),
		.target_vcn (target_vcn),
		.qstat      (qstat),
		.push       (push),
		.push_entry (push_entry)
	);

	erld_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.qstat      (qstat)
	);

	erld_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.qstat         (qstat),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.run_vcn_start (run_vcn_start),
		.run_lcn_start (run_lcn_start),
		.run_length    (run_length),
		.target_hit    (target_hit),
		.target_lcn    (target_lcn),
		.last_result   (last_result)
	);

endmodule

// ===== rtl/erld_checker.sv =====
// ----------------------------------------------------------------------------
// erld_checker
// Port-level checks on the decoder's result channel.
// ----------------------------------------------------------------------------
module erld_checker import erld_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  status,
	input logic [31:0] run_vcn_start,
	input logic [31:0] run_length,
	input logic        target_hit,
	input logic [31:0] target_lcn,
	input logic        last_result
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_term_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_RUN |-> last_result)
		else $error("end or malformed item not marked last");

	a_term_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_RUN |-> run_length == 32'd0 && !target_hit
			&& target_lcn == 32'd0 && run_vcn_start == 32'd0)
		else $error("end or malformed item carries run fields");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !target_hit |-> target_lcn == 32'd0)
		else $error("target cluster set without a hit");

	a_hit_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && target_hit |-> run_length != 32'd0 && status == ST_RUN)
		else $error("hit on an empty run");

endmodule

bind extent_run_list_decoder_top erld_checker u_erld_checker (.*);
